>>> rtl/vru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vru_pkg
// Types and constants shared by the vector refraction unit.
// ----------------------------------------------------------------------------
package vru_pkg;

  localparam int DataW   = 16;
  localparam int FracW   = 12;
  localparam int EtaW    = DataW - 1;

  localparam int SqRadW  = 48;
  localparam int SqRootW = SqRadW / 2;
  localparam int SqRemW  = SqRootW + 1;
  localparam int SqStages = SqRootW;

  typedef struct packed {
    logic signed [DataW-1:0] inc_x;
    logic signed [DataW-1:0] inc_y;
    logic signed [DataW-1:0] inc_z;
    logic signed [DataW-1:0] nrm_x;
    logic signed [DataW-1:0] nrm_y;
    logic signed [DataW-1:0] nrm_z;
    logic [EtaW-1:0]         index_ratio;
  } vru_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic                    total_reflection;
  } vru_out_t;

  typedef struct packed {
    vru_in_t            item;
    logic signed [23:0] eta_d;
    logic               tir;
  } vru_side_t;

endpackage
`default_nettype wire

>>> rtl/vru_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vru_isqrt
// Pipelined integer square root, one root bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module vru_isqrt
  import vru_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [SqRadW-1:0]   in_rad,
  input  wire vru_side_t           in_side,
  output logic                     out_valid,
  output logic [SqRootW-1:0]       out_root,
  output vru_side_t                out_side
);

  logic                  v_r    [SqStages];
  logic [SqRemW-1:0]     rem_r  [SqStages];
  logic [SqRootW-1:0]    root_r [SqStages];
  logic [SqRadW-1:0]     rad_r  [SqStages];
  vru_side_t             side_r [SqStages];

  for (genvar g = 0; g < SqStages; g++) begin : g_stage
    logic               v_i;
    logic [SqRemW-1:0]  rem_i;
    logic [SqRootW-1:0] root_i;
    logic [SqRadW-1:0]  rad_i;
    vru_side_t          side_i;
    logic [SqRemW+1:0]  trial;
    logic [SqRemW+1:0]  test;
    logic               fit;
    logic [SqRemW-1:0]  rem_nxt;
    logic [SqRootW-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign side_i = side_r[g-1];
    end

    always_comb begin
      trial    = {rem_i, rad_i[SqRadW-1 -: 2]};
      test     = {root_i, 2'b01};
      fit      = (trial >= test);
      rem_nxt  = fit ? SqRemW'(trial - test) : SqRemW'(trial);
      root_nxt = {root_i[SqRootW-2:0], fit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= {rad_i[SqRadW-3:0], 2'b00};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_valid = v_r[SqStages-1];
  assign out_root  = root_r[SqStages-1];
  assign out_side  = side_r[SqStages-1];

endmodule
`default_nettype wire

>>> rtl/vector_refraction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_refraction_unit
// Refract(I, N, eta) on Q4.12 three-vectors with total-reflection flag.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  in_      | in        | vru_in_t: incident, normal, index ratio
//  out_     | out       | vru_out_t: refracted vector, total reflection
//
//  One beat enters per cycle while in_stall is low; the pipe has six arithmetic
//  stages, 24 square-root stages of one root bit each and three output stages.
//  The whole pipe advances together; a stalled output beat freezes every stage
//  and in_stall rises in the same cycle.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module vector_refraction_unit
  import vru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire vru_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output vru_out_t      out_data
);

  localparam logic signed [37:0] OneK = 38'sd4096;
  localparam logic signed [29:0] OneO = 30'sd4096;
  localparam int Half = 2048;

  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 1: products
  logic                s1_v_r;
  vru_in_t             s1_item_r;
  logic signed [31:0]  s1_p_r [3];
  logic [29:0]         s1_e2_r;

  // stage 2: dot product, eta squared
  logic                s2_v_r;
  vru_in_t             s2_item_r;
  logic signed [20:0]  s2_d_r;
  logic [17:0]         s2_e2_r;
  logic signed [33:0]  s2_sum_nxt;
  logic [30:0]         s2_e2_nxt;

  // stage 3: d squared
  logic                s3_v_r;
  vru_in_t             s3_item_r;
  logic signed [20:0]  s3_d_r;
  logic [17:0]         s3_e2_r;
  logic signed [41:0]  s3_dd_r;

  // stage 4: one minus d squared
  logic                s4_v_r;
  vru_in_t             s4_item_r;
  logic signed [20:0]  s4_d_r;
  logic [17:0]         s4_e2_r;
  logic signed [29:0]  s4_om_r;
  logic signed [41:0]  s4_dd_nxt;
  logic [27:0]         s4_d2_nxt;

  // stage 5: eta^2 (1 - d^2), eta d
  logic                s5_v_r;
  vru_in_t             s5_item_r;
  logic signed [48:0]  s5_prod_r;
  logic signed [36:0]  s5_ed_r;

  // stage 6: k, radicand
  logic                s6_v_r;
  logic [SqRadW-1:0]   s6_rad_r;
  vru_side_t           s6_side_r;
  logic signed [48:0]  s6_pr_nxt;
  logic signed [37:0]  s6_k_nxt;
  logic signed [36:0]  s6_ed_nxt;

  // square root
  logic                sq_v;
  logic [SqRootW-1:0]  sq_root;
  vru_side_t           sq_side;

  // stage 31: c
  logic                s31_v_r;
  vru_side_t           s31_side_r;
  logic signed [25:0]  s31_c_r;

  // stage 32: component products
  logic                s32_v_r;
  logic                s32_tir_r;
  logic signed [31:0]  s32_a_r [3];
  logic signed [41:0]  s32_b_r [3];

  // output register
  logic                out_valid_r;
  vru_out_t            out_data_r;
  logic signed [DataW-1:0] res_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s31_v_r <= 1'b0;
      s32_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s31_v_r <= sq_v;
      s32_v_r <= s31_v_r;
      out_valid_r <= s32_v_r;
    end
  end

  always_comb begin
    s2_sum_nxt = 34'(s1_p_r[0]) + 34'(s1_p_r[1]) + 34'(s1_p_r[2]) + 34'sd2048;
    s2_e2_nxt  = 31'(s1_e2_r) + 31'(Half);
    s4_dd_nxt  = s3_dd_r + 42'sd2048;
    s4_d2_nxt  = s4_dd_nxt[39:12];
    s6_pr_nxt  = s5_prod_r + 49'sd2048;
    s6_k_nxt   = OneK - 38'($signed(s6_pr_nxt[48:12]));
    s6_ed_nxt  = s5_ed_r + 37'sd2048;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_data;
      s1_p_r[0] <= 32'(in_data.nrm_x * in_data.inc_x);
      s1_p_r[1] <= 32'(in_data.nrm_y * in_data.inc_y);
      s1_p_r[2] <= 32'(in_data.nrm_z * in_data.inc_z);
      s1_e2_r   <= 30'(in_data.index_ratio * in_data.index_ratio);

      s2_item_r <= s1_item_r;
      s2_d_r    <= s2_sum_nxt[32:12];
      s2_e2_r   <= s2_e2_nxt[29:12];

      s3_item_r <= s2_item_r;
      s3_d_r    <= s2_d_r;
      s3_e2_r   <= s2_e2_r;
      s3_dd_r   <= 42'(s2_d_r * s2_d_r);

      s4_item_r <= s3_item_r;
      s4_d_r    <= s3_d_r;
      s4_e2_r   <= s3_e2_r;
      s4_om_r   <= OneO - $signed({2'b00, s4_d2_nxt});

      s5_item_r <= s4_item_r;
      s5_prod_r <= 49'($signed({1'b0, s4_e2_r}) * s4_om_r);
      s5_ed_r   <= 37'($signed({1'b0, s4_item_r.index_ratio}) * s4_d_r);

      s6_side_r.item  <= s5_item_r;
      s6_side_r.eta_d <= s6_ed_nxt[35:12];
      s6_side_r.tir   <= s6_k_nxt[37];
      s6_rad_r        <= s6_k_nxt[37] ? '0 : {s6_k_nxt[35:0], 12'd0};

      s31_side_r <= sq_side;
      s31_c_r    <= 26'(sq_side.eta_d) + $signed({2'b00, sq_root});

      s32_tir_r  <= s31_side_r.tir;
      s32_a_r[0] <= 32'($signed({1'b0, s31_side_r.item.index_ratio}) * s31_side_r.item.inc_x);
      s32_a_r[1] <= 32'($signed({1'b0, s31_side_r.item.index_ratio}) * s31_side_r.item.inc_y);
      s32_a_r[2] <= 32'($signed({1'b0, s31_side_r.item.index_ratio}) * s31_side_r.item.inc_z);
      s32_b_r[0] <= 42'(s31_c_r * s31_side_r.item.nrm_x);
      s32_b_r[1] <= 42'(s31_c_r * s31_side_r.item.nrm_y);
      s32_b_r[2] <= 42'(s31_c_r * s31_side_r.item.nrm_z);

      out_data_r.out_x <= s32_tir_r ? '0 : res_nxt[0];
      out_data_r.out_y <= s32_tir_r ? '0 : res_nxt[1];
      out_data_r.out_z <= s32_tir_r ? '0 : res_nxt[2];
      out_data_r.total_reflection <= s32_tir_r;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_res
    logic signed [42:0] diff;
    logic signed [30:0] rr;
    always_comb begin
      diff = 43'(s32_a_r[j]) - 43'(s32_b_r[j]) + 43'sd2048;
      rr   = diff[42:12];
      if (rr > 31'sd32767) begin
        res_nxt[j] = 16'sh7fff;
      end else if (rr < -31'sd32768) begin
        res_nxt[j] = -16'sh8000;
      end else begin
        res_nxt[j] = rr[DataW-1:0];
      end
    end
  end

  vru_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s6_v_r),
    .in_rad    (s6_rad_r),
    .in_side   (s6_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_tir_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.total_reflection |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("total reflection beat with non-zero vector");

  a_rst_clear : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(s1_v_r) && $stable(s6_v_r) && $stable(s31_v_r))
    else $error("pipe moved while stalled");

endmodule
`default_nettype wire
